// File: src/fwwh_pkg.sv
`timescale 1ns / 1ps

package fwwh_pkg;

   localparam int ACTION_W = 2;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int VISIT_W  = 32;

   localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BDEQ = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TDEQ = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DELIVERED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STORED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WAITING     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ITEM_FULL   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_WAITER_FULL = 3'd5;

   typedef struct packed {
      logic take_req;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

// File: src/fwwh_if.sv
`timescale 1ns / 1ps

interface fwwh_req_if #(parameter int ITEM_WIDTH = 64);
   logic                          valid;
   logic                          ready;
   logic [fwwh_pkg::ACTION_W-1:0] action;
   logic [ITEM_WIDTH-1:0]         item_value;
   logic [fwwh_pkg::ID_W-1:0]     requester_id;

   modport source (output valid, action, item_value, requester_id, input ready);
   modport sink (input valid, action, item_value, requester_id, output ready);
endinterface

interface fwwh_rsp_if #(parameter int ITEM_WIDTH = 64);
   logic                          valid;
   logic                          ready;
   logic [fwwh_pkg::STATUS_W-1:0] status;
   logic [ITEM_WIDTH-1:0]         out_value;
   logic [fwwh_pkg::ID_W-1:0]     dest_id;
   logic [fwwh_pkg::COUNT_W-1:0]  item_count;
   logic [fwwh_pkg::COUNT_W-1:0]  waiter_count;
   logic [fwwh_pkg::VISIT_W-1:0]  visited_count;

   modport source (output valid, status, out_value, dest_id, item_count, waiter_count,
                   visited_count, input ready);
   modport sink (input valid, status, out_value, dest_id, item_count, waiter_count,
                 visited_count, output ready);
endinterface

// File: src/fwwh_ctrl.sv
`timescale 1ns / 1ps

module fwwh_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fwwh_pkg::dp_status_type  stat,
   output fwwh_pkg::ctrl_cmd_type   cmd
);
   import fwwh_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.take_req = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/fwwh_dpath.sv
`timescale 1ns / 1ps

module fwwh_dpath #(
   parameter int ITEM_DEPTH   = 16,
   parameter int WAITER_DEPTH = 16,
   parameter int ITEM_WIDTH   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fwwh_pkg::ctrl_cmd_type        cmd,
   output fwwh_pkg::dp_status_type       stat,
   input  logic [fwwh_pkg::ACTION_W-1:0] req_action,
   input  logic [ITEM_WIDTH-1:0]         req_item_value,
   input  logic [fwwh_pkg::ID_W-1:0]     req_requester_id,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [fwwh_pkg::STATUS_W-1:0] rsp_status,
   output logic [ITEM_WIDTH-1:0]         rsp_out_value,
   output logic [fwwh_pkg::ID_W-1:0]     rsp_dest_id,
   output logic [fwwh_pkg::COUNT_W-1:0]  rsp_item_count,
   output logic [fwwh_pkg::COUNT_W-1:0]  rsp_waiter_count,
   output logic [fwwh_pkg::VISIT_W-1:0]  rsp_visited_count
);
   import fwwh_pkg::*;

   localparam int IAW = $clog2(ITEM_DEPTH);
   localparam int ICW = $clog2(ITEM_DEPTH + 1);
   localparam int WAW = $clog2(WAITER_DEPTH);
   localparam int WCW = $clog2(WAITER_DEPTH + 1);

   localparam logic [IAW-1:0] ITEM_LAST   = IAW'(ITEM_DEPTH - 1);
   localparam logic [ICW-1:0] ITEM_FULL   = ICW'(ITEM_DEPTH);
   localparam logic [WAW-1:0] WAITER_LAST = WAW'(WAITER_DEPTH - 1);
   localparam logic [WCW-1:0] WAITER_FULL = WCW'(WAITER_DEPTH);

   logic [ITEM_WIDTH-1:0] item_mem_ff [ITEM_DEPTH];
   logic [ID_W-1:0]       waiter_mem_ff [WAITER_DEPTH];

   logic [ITEM_WIDTH-1:0] item_rd_ff;
   logic [ID_W-1:0]       waiter_rd_ff;

   logic [ACTION_W-1:0]   act_ff;
   logic [ITEM_WIDTH-1:0] value_ff;
   logic [ID_W-1:0]       id_ff;

   logic [IAW-1:0] item_head_ff, item_head_in;
   logic [IAW-1:0] item_tail_ff, item_tail_in;
   logic [ICW-1:0] items_held_ff, items_held_in;
   logic [WAW-1:0] waiter_head_ff, waiter_head_in;
   logic [WAW-1:0] waiter_tail_ff, waiter_tail_in;
   logic [WCW-1:0] waiters_held_ff, waiters_held_in;
   logic [VISIT_W-1:0] visited_ff, visited_in;

   logic item_we;
   logic waiter_we;

   logic [STATUS_W-1:0]   status_in;
   logic [ITEM_WIDTH-1:0] oval_in;
   logic [ID_W-1:0]       dest_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [ITEM_WIDTH-1:0] oval_ff;
   logic [ID_W-1:0]       dest_ff;
   logic [ICW-1:0]        icount_ff;
   logic [WCW-1:0]        wcount_ff;
   logic [VISIT_W-1:0]    vcount_ff;

   logic [ICW+COUNT_W-1:0] icount_ext;
   logic [WCW+COUNT_W-1:0] wcount_ext;

   always_comb begin
      item_head_in    = item_head_ff;
      item_tail_in    = item_tail_ff;
      items_held_in   = items_held_ff;
      waiter_head_in  = waiter_head_ff;
      waiter_tail_in  = waiter_tail_ff;
      waiters_held_in = waiters_held_ff;
      visited_in      = visited_ff;
      item_we         = 1'b0;
      waiter_we       = 1'b0;
      status_in       = ST_EMPTY;
      oval_in         = '0;
      dest_in         = '0;
      if (act_ff == ACT_ENQ) begin
         priority if (waiters_held_ff != '0) begin
            dest_in         = waiter_rd_ff;
            oval_in         = value_ff;
            waiter_head_in  = (waiter_head_ff == WAITER_LAST) ? '0 : waiter_head_ff + 1'b1;
            waiters_held_in = waiters_held_ff - 1'b1;
            visited_in      = visited_ff + 1'b1;
            status_in       = ST_DELIVERED;
         end else if (items_held_ff == ITEM_FULL) begin
            status_in = ST_ITEM_FULL;
         end else begin
            item_we       = cmd.commit;
            item_tail_in  = (item_tail_ff == ITEM_LAST) ? '0 : item_tail_ff + 1'b1;
            items_held_in = items_held_ff + 1'b1;
            status_in     = ST_STORED;
         end
      end else if (act_ff == ACT_BDEQ || act_ff == ACT_TDEQ) begin
         priority if (items_held_ff != '0) begin
            oval_in       = item_rd_ff;
            dest_in       = id_ff;
            item_head_in  = (item_head_ff == ITEM_LAST) ? '0 : item_head_ff + 1'b1;
            items_held_in = items_held_ff - 1'b1;
            visited_in    = visited_ff + 1'b1;
            status_in     = ST_DELIVERED;
         end else if (act_ff == ACT_TDEQ) begin
            status_in = ST_EMPTY;
         end else if (waiters_held_ff == WAITER_FULL) begin
            status_in = ST_WAITER_FULL;
         end else begin
            waiter_we       = cmd.commit;
            waiter_tail_in  = (waiter_tail_ff == WAITER_LAST) ? '0 : waiter_tail_ff + 1'b1;
            waiters_held_in = waiters_held_ff + 1'b1;
            status_in       = ST_WAITING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_we) begin
         item_mem_ff[item_tail_ff] <= value_ff;
      end
      if (cmd.take_req) begin
         item_rd_ff <= item_mem_ff[item_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (waiter_we) begin
         waiter_mem_ff[waiter_tail_ff] <= id_ff;
      end
      if (cmd.take_req) begin
         waiter_rd_ff <= waiter_mem_ff[waiter_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         act_ff   <= req_action;
         value_ff <= req_item_value;
         id_ff    <= req_requester_id;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         oval_ff   <= oval_in;
         dest_ff   <= dest_in;
         icount_ff <= items_held_in;
         wcount_ff <= waiters_held_in;
         vcount_ff <= visited_in;
      end
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_head_ff    <= '0;
         item_tail_ff    <= '0;
         items_held_ff   <= '0;
         waiter_head_ff  <= '0;
         waiter_tail_ff  <= '0;
         waiters_held_ff <= '0;
         visited_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.commit) begin
            item_head_ff    <= item_head_in;
            item_tail_ff    <= item_tail_in;
            items_held_ff   <= items_held_in;
            waiter_head_ff  <= waiter_head_in;
            waiter_tail_ff  <= waiter_tail_in;
            waiters_held_ff <= waiters_held_in;
            visited_ff      <= visited_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign icount_ext = {{COUNT_W{1'b0}}, icount_ff};
   assign wcount_ext = {{COUNT_W{1'b0}}, wcount_ff};

   assign stat.out_busy     = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_value     = oval_ff;
   assign rsp_dest_id       = dest_ff;
   assign rsp_item_count    = icount_ext[COUNT_W-1:0];
   assign rsp_waiter_count  = wcount_ext[COUNT_W-1:0];
   assign rsp_visited_count = vcount_ff;

endmodule

// File: src/fifo_with_waiter_handoff_core.sv
// Mailbox FIFO with a queue of waiting requesters.
// req_ch carries one request per transfer: action (enqueue, blocking dequeue,
// try dequeue), item_value and requester_id. rsp_ch returns exactly one result
// per request: status, out_value, dest_id and the item, waiter and visited counts.
// An enqueue goes straight to the oldest waiter when one is queued; a blocking
// dequeue on an empty store queues its requester if the waiter queue has room.
// A request is handled in order: when it is taken, the head entries of the item and
// waiter memories are read into registers along with the request; then, once the
// output register is free, pointers and counts are updated and the output register
// is loaded. A new request is taken only after the last one's result is loaded.
// The output register parts the channels: a new request is taken while a result
// waits; if rsp_ch stalls, the block holds the next result in its update cycle
// and stops taking requests until the output register drains.
// Reset (synchronous, active high) empties both queues and clears the visited
// count; the memories themselves are not cleared.
`timescale 1ns / 1ps

module fifo_with_waiter_handoff_core #(
   parameter int ITEM_DEPTH   = 16,
   parameter int WAITER_DEPTH = 16,
   parameter int ITEM_WIDTH   = 64
) (
   input logic  clock,
   input logic  reset,
   fwwh_req_if.sink   req_ch,
   fwwh_rsp_if.source rsp_ch
);
   import fwwh_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   fwwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fwwh_dpath #(
      .ITEM_DEPTH   (ITEM_DEPTH),
      .WAITER_DEPTH (WAITER_DEPTH),
      .ITEM_WIDTH   (ITEM_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_ch.action),
      .req_item_value    (req_ch.item_value),
      .req_requester_id  (req_ch.requester_id),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_out_value     (rsp_ch.out_value),
      .rsp_dest_id       (rsp_ch.dest_id),
      .rsp_item_count    (rsp_ch.item_count),
      .rsp_waiter_count  (rsp_ch.waiter_count),
      .rsp_visited_count (rsp_ch.visited_count)
   );

endmodule

// File: src/fwwh_chk.sv
`timescale 1ns / 1ps

module fwwh_chk #(
   parameter int ITEM_WIDTH = 64
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fwwh_pkg::STATUS_W-1:0] rsp_status,
   input logic [ITEM_WIDTH-1:0]         rsp_out_value,
   input logic [fwwh_pkg::ID_W-1:0]     rsp_dest_id,
   input logic [fwwh_pkg::COUNT_W-1:0]  rsp_item_count,
   input logic [fwwh_pkg::COUNT_W-1:0]  rsp_waiter_count
);
   import fwwh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_value) && $stable(rsp_dest_id))
      else $error("result changed while stalled");

   a_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DELIVERED |-> rsp_out_value == '0 && rsp_dest_id == '0)
      else $error("payload on a result that delivers nothing");

   a_wait_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_WAITING |-> rsp_item_count == '0)
      else $error("requester queued while items are held");

   a_store_nowait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STORED |-> rsp_waiter_count == '0)
      else $error("item stored while requesters wait");

endmodule

bind fifo_with_waiter_handoff_core fwwh_chk #(.ITEM_WIDTH(ITEM_WIDTH)) u_fwwh_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_out_value    (rsp_ch.out_value),
   .rsp_dest_id      (rsp_ch.dest_id),
   .rsp_item_count   (rsp_ch.item_count),
   .rsp_waiter_count (rsp_ch.waiter_count)
);

// File: tb/sv/tb_fifo_with_waiter_handoff_core.sv
`timescale 1ns / 1ps

module tb_fifo_with_waiter_handoff_core;
   import fwwh_pkg::*;

   localparam int ITEM_DEPTH   = 16;
   localparam int WAITER_DEPTH = 16;
   localparam int ITEM_WIDTH   = 64;
   localparam int CLK_HALF     = 6;
   localparam int IDLE_PCT     = 28;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [ITEM_WIDTH-1:0] out_value;
      logic [ID_W-1:0]       dest_id;
      logic [COUNT_W-1:0]    item_count;
      logic [COUNT_W-1:0]    waiter_count;
      logic [VISIT_W-1:0]    visited_count;
   } mbox_result_type;

   logic clock;
   logic reset;

   fwwh_req_if #(.ITEM_WIDTH(ITEM_WIDTH)) req_ch ();
   fwwh_rsp_if #(.ITEM_WIDTH(ITEM_WIDTH)) rsp_ch ();

   fifo_with_waiter_handoff_core #(
      .ITEM_DEPTH(ITEM_DEPTH),
      .WAITER_DEPTH(WAITER_DEPTH),
      .ITEM_WIDTH(ITEM_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [ITEM_WIDTH-1:0] item_mem [ITEM_DEPTH];
   int unsigned           item_rd;
   int unsigned           item_wr;
   int unsigned           item_cnt;
   logic [ID_W-1:0]       waiter_mem [WAITER_DEPTH];
   int unsigned           waiter_rd;
   int unsigned           waiter_wr;
   int unsigned           waiter_cnt;
   logic [VISIT_W-1:0]    visits;

   mbox_result_type pending_results [$];
   int              error_count;
   int              requests_sent;
   int              stall_cycles;
   int              status_seen [6];
   bit              no_idle;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   function automatic mbox_result_type predict_mailbox(input logic [ACTION_W-1:0] act,
                                                       input logic [ITEM_WIDTH-1:0] value,
                                                       input logic [ID_W-1:0] id);
      mbox_result_type r;
      r = '0;
      r.status = ST_EMPTY;
      if (act == ACT_ENQ) begin
         if (waiter_cnt > 0) begin
            r.dest_id = waiter_mem[waiter_rd];
            waiter_rd = (waiter_rd + 1) % WAITER_DEPTH;
            waiter_cnt--;
            r.out_value = value;
            visits++;
            r.status = ST_DELIVERED;
         end else if (item_cnt >= ITEM_DEPTH) begin
            r.status = ST_ITEM_FULL;
         end else begin
            item_mem[item_wr] = value;
            item_wr = (item_wr + 1) % ITEM_DEPTH;
            item_cnt++;
            r.status = ST_STORED;
         end
      end else if (act == ACT_BDEQ || act == ACT_TDEQ) begin
         if (item_cnt > 0) begin
            r.out_value = item_mem[item_rd];
            item_rd = (item_rd + 1) % ITEM_DEPTH;
            item_cnt--;
            r.dest_id = id;
            visits++;
            r.status = ST_DELIVERED;
         end else if (act == ACT_TDEQ) begin
            r.status = ST_EMPTY;
         end else if (waiter_cnt >= WAITER_DEPTH) begin
            r.status = ST_WAITER_FULL;
         end else begin
            waiter_mem[waiter_wr] = id;
            waiter_wr = (waiter_wr + 1) % WAITER_DEPTH;
            waiter_cnt++;
            r.status = ST_WAITING;
         end
      end
      r.item_count    = COUNT_W'(item_cnt);
      r.waiter_count  = COUNT_W'(waiter_cnt);
      r.visited_count = visits;
      return r;
   endfunction

   task automatic check_result(input mbox_result_type want);
      if (rsp_ch.status !== want.status) begin
         error_count++;
         $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
      end
      if (rsp_ch.out_value !== want.out_value) begin
         error_count++;
         $error("out_value: expected %h, got %h", want.out_value, rsp_ch.out_value);
      end
      if (rsp_ch.dest_id !== want.dest_id) begin
         error_count++;
         $error("dest_id: expected %0d, got %0d", want.dest_id, rsp_ch.dest_id);
      end
      if (rsp_ch.item_count !== want.item_count) begin
         error_count++;
         $error("item_count: expected %0d, got %0d", want.item_count, rsp_ch.item_count);
      end
      if (rsp_ch.waiter_count !== want.waiter_count) begin
         error_count++;
         $error("waiter_count: expected %0d, got %0d", want.waiter_count,
                rsp_ch.waiter_count);
      end
      if (rsp_ch.visited_count !== want.visited_count) begin
         error_count++;
         $error("visited_count: expected %0d, got %0d", want.visited_count,
                rsp_ch.visited_count);
      end
   endtask

   always @(posedge clock) begin : result_monitor
      mbox_result_type want;
      bit              moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (rsp_ch.status <= ST_WAITER_FULL)
               status_seen[rsp_ch.status]++;
            if (pending_results.size() == 0) begin
               error_count++;
               $error("result with no request outstanding: status %0d", rsp_ch.status);
            end else begin
               want = pending_results.pop_front();
               check_result(want);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            pending_results.push_back(predict_mailbox(req_ch.action, req_ch.item_value,
                                                      req_ch.requester_id));
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [ITEM_WIDTH-1:0] value,
                               input logic [ID_W-1:0] id);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.item_value   <= value;
      req_ch.requester_id <= id;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic logic [ITEM_WIDTH-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return '0;
      if (sel == 1)
         return '1;
      return ITEM_WIDTH'({$urandom, $urandom});
   endfunction

   task automatic send_burst(input int count, input int w_enq, input int w_bdeq,
                             input int w_tdeq, input int w_odd);
      int                  pick;
      int                  total;
      logic [ACTION_W-1:0] act;
      total = w_enq + w_bdeq + w_tdeq + w_odd;
      repeat (count) begin
         pick = $urandom_range(0, total - 1);
         if (pick < w_enq)
            act = ACT_ENQ;
         else if (pick < w_enq + w_bdeq)
            act = ACT_BDEQ;
         else if (pick < w_enq + w_bdeq + w_tdeq)
            act = ACT_TDEQ;
         else
            act = ACT_UNUSED;
         send_request(act, pick_value(), ID_W'($urandom_range(0, 15)));
      end
   endtask

   task automatic test_directed_basics();
      send_request(ACT_TDEQ, '0, 4'd1);
      send_request(ACT_UNUSED, '1, 4'd2);
      send_request(ACT_BDEQ, '0, 4'd15);
      send_request(ACT_BDEQ, '1, 4'd0);
      send_request(ACT_ENQ, '1, 4'd9);
      send_request(ACT_ENQ, '0, 4'd6);
      send_request(ACT_ENQ, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0);
      send_request(ACT_ENQ, 64'h5A5A_5A5A_5A5A_5A5A, 4'd15);
      send_request(ACT_UNUSED, '1, 4'd15);
      send_request(ACT_BDEQ, '1, 4'd7);
      send_request(ACT_TDEQ, '0, 4'd8);
      send_request(ACT_TDEQ, '1, 4'd3);
   endtask

   task automatic test_item_store_full();
      repeat (4) begin
         send_burst(40, 85, 5, 5, 5);
         send_burst(40, 5, 45, 45, 5);
      end
   endtask

   task automatic test_waiter_store_full();
      repeat (4) begin
         send_burst(45, 5, 85, 5, 5);
         send_burst(45, 85, 5, 5, 5);
      end
   endtask

   task automatic test_random_mix();
      no_idle = 1'b1;
      send_burst(300, 40, 30, 25, 5);
      no_idle = 1'b0;
      repeat (10) begin
         send_burst(100, $urandom_range(1, 60), $urandom_range(1, 60),
                    $urandom_range(1, 40), $urandom_range(1, 5));
      end
   endtask

   initial begin : stimulus
      int drain_wait;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_ENQ;
      req_ch.item_value   = '0;
      req_ch.requester_id = '0;
      rsp_ch.ready        = 1'b0;
      no_idle             = 1'b0;
      item_rd             = 0;
      item_wr             = 0;
      item_cnt            = 0;
      waiter_rd           = 0;
      waiter_wr           = 0;
      waiter_cnt          = 0;
      visits              = '0;
      error_count         = 0;
      requests_sent       = 0;
      stall_cycles        = 0;
      foreach (status_seen[i]) status_seen[i] = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_basics();
      test_item_store_full();
      test_waiter_store_full();
      test_random_mix();
      req_ch.valid <= 1'b0;

      drain_wait = 0;
      while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) begin
         error_count++;
         $error("%0d results never arrived", pending_results.size());
      end
      $display("Run covered %0d requests over all four action codes, handoffs to waiters,",
               requests_sent);
      $display("and both store limits; results by status 0..5: %0d %0d %0d %0d %0d %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5]);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
